// File: design/odrp_pkg.sv
// ============================================================================
// odrp_pkg
// Shared types and constants of the diagnostic response parser: operation
// codes, service identifiers, field widths and the code table entry layout.
// ============================================================================
`default_nettype none

package odrp_pkg;

    // Field widths
    localparam int RAW_W    = 32;   // odometer raw reading
    localparam int MILE_W   = 29;   // mileage after divide by ten
    localparam int CODE_W   = 24;   // raw code bytes, right aligned
    localparam int CNT_W    = 6;    // code count
    localparam int VCNT_W   = 5;    // VIN length
    localparam int IDX_W    = 5;    // read index
    localparam int CHAR_W   = 7;    // VIN character

    // Code table size is bounded by the 5-bit read index and 6-bit count
    localparam int MAX_CODES = 32;
    localparam int CODE_AW   = $clog2(MAX_CODES);

    // Odometer scale
    localparam logic [4:0] ODO_DIVISOR = 5'd10;

    // Operations
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // Service and sub-function bytes
    localparam logic [7:0] SVC_OBD_DTC   = 8'h43;
    localparam logic [7:0] SVC_PID       = 8'h41;
    localparam logic [7:0] PID_ODOMETER  = 8'hA6;
    localparam logic [7:0] SVC_VEH_INFO  = 8'h49;
    localparam logic [7:0] INFO_VIN      = 8'h02;
    localparam logic [7:0] UDS_READ_DTC  = 8'h19;
    localparam logic [7:0] UDS_POS_RESP  = 8'h40;
    localparam logic [7:0] SVC_UDS_DTC   = UDS_READ_DTC | UDS_POS_RESP;
    localparam logic [7:0] UDS_DTC_BY_MASK = 8'h02;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;

    // Printable VIN characters, space excluded
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;

    // Code kinds
    localparam logic KIND_OBD = 1'b0;
    localparam logic KIND_UDS = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] value;
    } t_code_entry;

    localparam int ENTRY_W = $bits(t_code_entry);

endpackage

`default_nettype wire

// File: design/odrp_ram.sv
// ============================================================================
// odrp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
`default_nettype none

module odrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/odrp_div10.sv
// ============================================================================
// odrp_div10
// Divide by ten of the odometer reading by reciprocal multiplication: the
// dividend is registered, then the quotient taken from the product is
// registered together with o_done.
// ============================================================================
`default_nettype none

module odrp_div10
    import odrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAW_W-1:0]  i_dividend,
    output logic                   o_done,
    output logic      [MILE_W-1:0] o_quotient
);

    localparam int PROD_W = 2 * RAW_W;
    // ceil(2^35 / 10): the product shifted right by 35 is the exact quotient
    // for every 32-bit dividend
    localparam logic [RAW_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int               SHIFT    = 35;

    logic              r_busy;
    logic              r_done;
    logic [RAW_W-1:0]  r_dividend;
    logic [MILE_W-1:0] r_quotient;

    logic [PROD_W-1:0] product;

    assign product = PROD_W'(r_dividend) * PROD_W'(RECIP_10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
            if (i_start) begin
                r_dividend <= i_dividend;
            end
            if (r_busy) begin
                r_quotient <= product[SHIFT +: MILE_W];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quotient;

endmodule

`default_nettype wire

// File: design/obd_diagnostic_response_parser_unit.sv
// ============================================================================
// obd_diagnostic_response_parser_unit
// Parses OBD and UDS diagnostic responses byte by byte into a code table,
// odometer mileage and VIN, and answers read and clear operations.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one operation per transfer:
//   a message byte with its end-of-message mark, a code table clear, or a
//   read of one table entry and one VIN character. The output channel
//   (o_out_valid / i_out_stall) returns exactly one result per operation,
//   in order: counts, mileage and, for a read, the entry and character.
//   One operation is in flight at a time; o_in_stall is high from the
//   transfer until the result is loaded into the output register.
//   Steps per operation, transfer to result valid:
//     clear, plain byte, unused op : straight to the result load
//     read                         : RAM read, then the result load
//     byte completing a code       : duplicate scan, reading one table entry
//                                    per cycle, append if unmatched, load
//     byte completing the odometer : divide by ten, then the result load
//   A stalled result holds in the output register; the next operation may
//   transfer while it waits, but its own result waits for the register.
//   Synchronous reset clears counts, mileage and parse state; the table and
//   VIN memories are not cleared and are read only below their counts.
// ============================================================================
`default_nettype none

module obd_diagnostic_response_parser_unit
    import odrp_pkg::*;
#(
    parameter int MAX_MESSAGE = 256,
    parameter int VIN_CHARS   = 19
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // operation input
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_end_of_message,
    input  wire logic [IDX_W-1:0]  i_read_index,
    // result output
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [CNT_W-1:0]  o_code_count,
    output logic      [MILE_W-1:0] o_mileage,
    output logic      [VCNT_W-1:0] o_vin_length,
    output logic                   o_entry_valid,
    output logic                   o_entry_kind,
    output logic      [CODE_W-1:0] o_entry_value,
    output logic      [CHAR_W-1:0] o_vin_char
);

    localparam int POS_W  = $clog2(MAX_MESSAGE + 1);
    localparam int VIN_AW = $clog2(VIN_CHARS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;

    // Parse state
    logic [POS_W-1:0]  r_pos;
    logic [7:0]        r_service;
    logic [7:0]        r_second;
    logic [23:0]       r_partial;      // last three bytes received
    logic              r_pair_stop;
    logic [CNT_W-1:0]  r_stored_count;
    logic [MILE_W-1:0] r_mileage;
    logic [VCNT_W-1:0] r_vin_count;

    // Duplicate scan
    t_code_entry       r_new_entry;
    logic [CNT_W-1:0]  r_scan_idx;
    logic              r_chk;          // RAM data of last issued read is due

    // Read operation
    logic              r_rd_hit;
    logic              r_ch_hit;
    logic              r_res_valid;
    logic              r_res_kind;
    logic [CODE_W-1:0] r_res_value;
    logic [CHAR_W-1:0] r_res_char;

    // Output register
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_count;
    logic [MILE_W-1:0] r_out_mileage;
    logic [VCNT_W-1:0] r_out_vin_len;
    logic              r_out_entry_valid;
    logic              r_out_kind;
    logic [CODE_W-1:0] r_out_value;
    logic [CHAR_W-1:0] r_out_char;

    // ------------------------------------------------------------------
    // Byte decode at the input transfer
    // ------------------------------------------------------------------
    logic       accept;
    t_op        op;
    logic       op_byte;
    logic       pos_ok;
    logic       pos_zero;
    logic [7:0] sec_eff;
    logic       is_obd_pair;
    logic       obd_stop;
    logic       obd_add;
    logic       uds_add;
    logic       odo_done;
    logic       vin_msg;
    logic       vin_clear;
    logic       vin_keep;
    logic       table_full;
    t_code_entry new_entry;

    assign accept   = i_in_valid && !o_in_stall;
    assign op       = t_op'(i_operation);
    assign op_byte  = (op == OP_BYTE);
    assign pos_ok   = (r_pos < POS_W'(MAX_MESSAGE));
    assign pos_zero = (r_pos == '0);
    // second byte as it stands after this byte is taken
    assign sec_eff  = (r_pos == POS_W'(1)) ? i_data_byte : r_second;

    assign is_obd_pair = !pos_zero && (r_service == SVC_OBD_DTC) && !r_pos[0] && !r_pair_stop;
    assign obd_stop    = is_obd_pair && (r_partial[7:0] == BYTE_ZERO)
                         && (i_data_byte == BYTE_ZERO);
    assign obd_add     = is_obd_pair && !obd_stop;
    assign uds_add     = !pos_zero && (r_service == SVC_UDS_DTC)
                         && (sec_eff == UDS_DTC_BY_MASK)
                         && (r_pos >= POS_W'(6)) && (r_pos[1:0] == 2'b10);
    assign odo_done    = !pos_zero && (r_service == SVC_PID)
                         && (sec_eff == PID_ODOMETER) && (r_pos == POS_W'(5));
    assign vin_msg     = !pos_zero && (r_service == SVC_VEH_INFO) && (sec_eff == INFO_VIN);
    assign vin_clear   = vin_msg && (r_pos == POS_W'(2));
    assign vin_keep    = vin_msg && (r_pos >= POS_W'(3))
                         && (r_vin_count < VCNT_W'(VIN_CHARS))
                         && (i_data_byte > CHAR_SPACE) && (i_data_byte <= CHAR_LAST);
    assign table_full  = (r_stored_count >= CNT_W'(MAX_CODES));

    always_comb begin
        new_entry = '0;
        if (uds_add) begin
            new_entry.kind  = KIND_UDS;
            new_entry.value = r_partial;
        end else begin
            new_entry.kind  = KIND_OBD;
            new_entry.value = {8'h00, r_partial[7:0], i_data_byte};
        end
    end

    // ------------------------------------------------------------------
    // Code table memory: lookup reads during the scan, entry reads on a
    // read operation, append write at the end of an unmatched scan
    // ------------------------------------------------------------------
    logic                scan_rd;
    logic                code_rd_en;
    logic [CODE_AW-1:0]  code_rd_addr;
    logic                code_wr_en;
    logic [ENTRY_W-1:0]  code_rd_data;
    logic                scan_match;

    assign scan_rd      = (r_state == S_SCAN) && (r_scan_idx < r_stored_count);
    assign code_rd_en   = scan_rd || (accept && (op == OP_READ));
    assign code_rd_addr = (r_state == S_SCAN) ? r_scan_idx[CODE_AW-1:0]
                                              : i_read_index[CODE_AW-1:0];
    assign code_wr_en   = (r_state == S_SCAN) && !scan_rd && !r_chk;
    assign scan_match   = r_chk && (code_rd_data == r_new_entry);

    odrp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CODES)
    ) u_code_ram (
        .i_clk     (i_clk),
        .i_wr_en   (code_wr_en),
        .i_wr_addr (r_stored_count[CODE_AW-1:0]),
        .i_wr_data (r_new_entry),
        .i_rd_en   (code_rd_en),
        .i_rd_addr (code_rd_addr),
        .o_rd_data (code_rd_data)
    );

    // ------------------------------------------------------------------
    // VIN memory: append on a kept character, read on a read operation
    // ------------------------------------------------------------------
    logic              vin_wr_en;
    logic              vin_rd_en;
    logic [CHAR_W-1:0] vin_rd_data;

    assign vin_wr_en = accept && op_byte && pos_ok && vin_keep;
    assign vin_rd_en = accept && (op == OP_READ);

    odrp_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (VIN_CHARS)
    ) u_vin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (vin_wr_en),
        .i_wr_addr (r_vin_count[VIN_AW-1:0]),
        .i_wr_data (i_data_byte[CHAR_W-1:0]),
        .i_rd_en   (vin_rd_en),
        .i_rd_addr (i_read_index[VIN_AW-1:0]),
        .o_rd_data (vin_rd_data)
    );

    // ------------------------------------------------------------------
    // Odometer divide by ten
    // ------------------------------------------------------------------
    logic              div_start;
    logic              div_done;
    logic [MILE_W-1:0] div_quot;

    assign div_start = accept && op_byte && pos_ok && odo_done;

    odrp_div10 u_div10 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_partial, i_data_byte}),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer, state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pos          <= '0;
            r_service      <= '0;
            r_second       <= '0;
            r_partial      <= '0;
            r_pair_stop    <= 1'b0;
            r_stored_count <= '0;
            r_mileage      <= '0;
            r_vin_count    <= '0;
            r_chk          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // retire a result taken by the receiver
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_valid <= 1'b0;
                        r_res_kind  <= 1'b0;
                        r_res_value <= '0;
                        r_res_char  <= '0;
                        r_state     <= S_DONE;
                        case (op)
                            OP_BYTE: begin
                                if (pos_ok) begin
                                    if (pos_zero) begin
                                        r_service <= i_data_byte;
                                    end
                                    if (r_pos == POS_W'(1)) begin
                                        r_second <= i_data_byte;
                                    end
                                    if (obd_stop) begin
                                        r_pair_stop <= 1'b1;
                                    end
                                    if (vin_clear) begin
                                        r_vin_count <= '0;
                                    end else if (vin_keep) begin
                                        r_vin_count <= r_vin_count + 1'b1;
                                    end
                                    r_partial <= {r_partial[15:0], i_data_byte};
                                    r_pos     <= r_pos + 1'b1;
                                    if ((obd_add || uds_add) && !table_full) begin
                                        r_new_entry <= new_entry;
                                        r_scan_idx  <= '0;
                                        r_chk       <= 1'b0;
                                        r_state     <= S_SCAN;
                                    end else if (odo_done) begin
                                        r_state <= S_DIV;
                                    end
                                end
                                // end of message restarts the parse
                                if (i_end_of_message) begin
                                    r_pos       <= '0;
                                    r_pair_stop <= 1'b0;
                                end
                            end
                            OP_CLEAR: begin
                                r_stored_count <= '0;
                            end
                            OP_READ: begin
                                r_rd_hit <= ({1'b0, i_read_index} < r_stored_count);
                                r_ch_hit <= (i_read_index < r_vin_count);
                                r_state  <= S_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    // one table entry read per cycle, compared in the cycle after its read
                    r_chk <= scan_rd;
                    if (scan_rd) begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                    if (scan_match) begin
                        r_state <= S_DONE;
                    end else if (code_wr_en) begin
                        r_stored_count <= r_stored_count + 1'b1;
                        r_state        <= S_DONE;
                    end
                end

                S_DIV: begin
                    if (div_done) begin
                        r_mileage <= div_quot;
                        r_state   <= S_DONE;
                    end
                end

                S_READ: begin
                    r_res_valid <= r_rd_hit;
                    if (r_rd_hit) begin
                        r_res_kind  <= code_rd_data[ENTRY_W-1];
                        r_res_value <= code_rd_data[CODE_W-1:0];
                    end
                    if (r_ch_hit) begin
                        r_res_char <= vin_rd_data;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // load once the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid       <= 1'b1;
                        r_out_count       <= r_stored_count;
                        r_out_mileage     <= r_mileage;
                        r_out_vin_len     <= r_vin_count;
                        r_out_entry_valid <= r_res_valid;
                        r_out_kind        <= r_res_kind;
                        r_out_value       <= r_res_value;
                        r_out_char        <= r_res_char;
                        r_state           <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_code_count  = r_out_count;
    assign o_mileage     = r_out_mileage;
    assign o_vin_length  = r_out_vin_len;
    assign o_entry_valid = r_out_entry_valid;
    assign o_entry_kind  = r_out_kind;
    assign o_entry_value = r_out_value;
    assign o_vin_char    = r_out_char;

endmodule

`default_nettype wire

// File: sim/obd_diagnostic_response_parser_unit_test.sv
// ----------------------------------------------------------------------------
// obd_diagnostic_response_parser_unit_test
// Self-checking bench for the diagnostic response parser. A queue of
// operations (message bytes, clears, reads and the unused code) feeds a
// valid/stall driver. An in-bench model of the parser predicts one result per
// accepted transfer, and a monitor compares every result field by field.
// ----------------------------------------------------------------------------
module obd_diagnostic_response_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import odrp_pkg::*;

    localparam int MSG_LIMIT   = 256;      // bytes kept per message
    localparam int VIN_MAX     = 19;       // VIN characters kept
    localparam int STIM_ITEMS  = 1300;     // stop generating past this many
    localparam int QUIET_TAIL  = 150;      // no idling once this few remain
    localparam int LONG_HOLD   = 250;      // receiver hold-off, in cycles
    localparam int DRAIN_WAIT  = 60;       // covers the slowest operation
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 50;

    // The package names three operations; the fourth code is unused
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One operation as offered on the input channel
    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       data;
        logic             eom;
        logic [IDX_W-1:0] idx;
    } t_op_item;

    // One result as returned on the output channel
    typedef struct packed {
        logic [CNT_W-1:0]  code_count;
        logic [MILE_W-1:0] mileage;
        logic [VCNT_W-1:0] vin_length;
        logic              entry_valid;
        logic              entry_kind;
        logic [CODE_W-1:0] entry_value;
        logic [CHAR_W-1:0] vin_char;
    } t_parse_result;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_operation      = OP_BYTE;
    logic [7:0]        i_data_byte      = 8'h00;
    logic              i_end_of_message = 1'b0;
    logic [IDX_W-1:0]  i_read_index     = '0;
    logic              o_out_valid;
    logic              i_out_stall      = 1'b0;
    logic [CNT_W-1:0]  o_code_count;
    logic [MILE_W-1:0] o_mileage;
    logic [VCNT_W-1:0] o_vin_length;
    logic              o_entry_valid;
    logic              o_entry_kind;
    logic [CODE_W-1:0] o_entry_value;
    logic [CHAR_W-1:0] o_vin_char;

    obd_diagnostic_response_parser_unit #(
        .MAX_MESSAGE (MSG_LIMIT),
        .VIN_CHARS   (VIN_MAX)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_read_index     (i_read_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_code_count     (o_code_count),
        .o_mileage        (o_mileage),
        .o_vin_length     (o_vin_length),
        .o_entry_valid    (o_entry_valid),
        .o_entry_kind     (o_entry_kind),
        .o_entry_value    (o_entry_value),
        .o_vin_char       (o_vin_char)
    );

    // ------------------------------------------------------------------------
    // Parser model state: message parse, code table, odometer and VIN
    // ------------------------------------------------------------------------
    int           msg_pos;           // saturates at MSG_LIMIT
    logic [7:0]   svc_byte;
    logic [7:0]   sub_byte;
    logic [23:0]  last_bytes;        // three most recent message bytes
    bit           pairs_stopped;     // a 00 00 pair ended OBD decoding
    t_code_entry  code_tab [MAX_CODES];
    int           n_codes;
    logic [MILE_W-1:0] odo_miles;
    logic [CHAR_W-1:0] vin_chars [VIN_MAX];
    int           vin_len;

    // Bench bookkeeping
    t_op_item      op_backlog[$];       // operations not yet offered
    t_parse_result pending_results[$];  // predicted, not yet returned
    t_op_item      cur_item;            // operation currently offered
    int            n_stim, n_sent, n_checked, n_errors, n_cycles;
    int            n_reads, n_hits, n_clears, n_fills;
    int            gap_left, stall_left, hold_cycles;
    bit            hold_done;

    // Append a code unless the table is full or holds the same kind and value
    function automatic void store_code(input logic kind, input logic [CODE_W-1:0] value);
        t_code_entry entry;
        bit          dup;
        entry = '{kind: kind, value: value};
        dup   = 1'b0;
        for (int i = 0; i < n_codes; i++)
            if (code_tab[i] == entry)
                dup = 1'b1;
        if (n_codes < MAX_CODES && !dup) begin
            code_tab[n_codes] = entry;
            n_codes++;
            if (n_codes == MAX_CODES)
                n_fills++;
        end
    endfunction

    // Advance the model by one operation and return the result it produces
    function automatic t_parse_result next_parser_result(input t_op_item it);
        t_parse_result r;
        logic [7:0]    b;
        logic [RAW_W-1:0] raw;
        r = '0;
        b = it.data;
        case (it.op)
            OP_BYTE: begin
                if (msg_pos < MSG_LIMIT) begin
                    if (msg_pos == 0) begin
                        svc_byte = b;
                    end else begin
                        if (msg_pos == 1)
                            sub_byte = b;
                        // OBD pairs sit at (1,2), (3,4), ...; 00 00 ends them
                        if (svc_byte == SVC_OBD_DTC && (msg_pos % 2) == 0 && !pairs_stopped) begin
                            if (last_bytes[7:0] == BYTE_ZERO && b == BYTE_ZERO)
                                pairs_stopped = 1'b1;
                            else
                                store_code(KIND_OBD, {8'h00, last_bytes[7:0], b});
                        end
                        // UDS record complete on its status byte: keep the three code bytes
                        if (svc_byte == SVC_UDS_DTC && sub_byte == UDS_DTC_BY_MASK &&
                            msg_pos >= 6 && (msg_pos % 4) == 2)
                            store_code(KIND_UDS, last_bytes);
                        if (svc_byte == SVC_PID && sub_byte == PID_ODOMETER && msg_pos == 5) begin
                            raw       = {last_bytes, b};
                            odo_miles = MILE_W'(raw / RAW_W'(ODO_DIVISOR));
                        end
                        if (svc_byte == SVC_VEH_INFO && sub_byte == INFO_VIN) begin
                            if (msg_pos == 2) begin
                                vin_len = 0;
                            end else if (msg_pos >= 3 && vin_len < VIN_MAX &&
                                         b > CHAR_SPACE && b <= CHAR_LAST) begin
                                vin_chars[vin_len] = b[CHAR_W-1:0];
                                vin_len++;
                            end
                        end
                    end
                    last_bytes = {last_bytes[15:0], b};
                    msg_pos++;
                end
                if (it.eom) begin
                    msg_pos       = 0;
                    pairs_stopped = 1'b0;
                end
            end
            OP_CLEAR: begin
                n_codes = 0;
                n_clears++;
            end
            OP_READ: begin
                n_reads++;
                if (it.idx < n_codes) begin
                    n_hits++;
                    r.entry_valid = 1'b1;
                    r.entry_kind  = code_tab[it.idx].kind;
                    r.entry_value = code_tab[it.idx].value;
                end
                if (it.idx < vin_len)
                    r.vin_char = vin_chars[it.idx];
            end
            default: ;
        endcase
        r.code_count = CNT_W'(n_codes);
        r.mileage    = odo_miles;
        r.vin_length = VCNT_W'(vin_len);
        return r;
    endfunction

    // Idle bursts stop near the end and pause in every third window of transfers
    function automatic bit idling_allowed();
        return op_backlog.size() >= QUIET_TAIL && ((n_sent / 120) % 3) != 2;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: offer the backlog, hold a stalled transfer, insert idle bursts
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit fire;
        bit keep;
        fire = i_in_valid && !o_in_stall;
        if (fire) begin
            // Predict on acceptance so the model sees operations in block order
            pending_results.push_back(next_parser_result(cur_item));
            n_sent++;
        end
        keep = i_in_valid && !fire;
        if (i_rst_n && !keep) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (op_backlog.size() != 0 && idling_allowed() &&
                         $urandom_range(0, 5) == 0) begin
                // Start an idle burst; gap_left sets its random extra length
                gap_left = $urandom_range(0, 3);
                i_in_valid <= 1'b0;
            end else if (op_backlog.size() != 0) begin
                cur_item = op_backlog.pop_front();
                i_in_valid       <= 1'b1;
                i_operation      <= cur_item.op;
                i_data_byte      <= cur_item.data;
                i_end_of_message <= cur_item.eom;
                i_read_index     <= cur_item.idx;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each returned result against the oldest prediction,
    // then choose the stall for the next cycle
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_parse_result want;
        bit            burst;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                $error("result returned with no operation outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("code_count",  32'(want.code_count),  32'(o_code_count));
                check_field("mileage",     32'(want.mileage),     32'(o_mileage));
                check_field("vin_length",  32'(want.vin_length),  32'(o_vin_length));
                check_field("entry_valid", 32'(want.entry_valid), 32'(o_entry_valid));
                check_field("entry_kind",  32'(want.entry_kind),  32'(o_entry_kind));
                check_field("entry_value", 32'(want.entry_value), 32'(o_entry_value));
                check_field("vin_char",    32'(want.vin_char),    32'(o_vin_char));
            end
            n_checked++;
        end
        if (stall_left != 0) begin
            stall_left--;
            burst = 1'b1;
        end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            burst      = 1'b1;
        end else begin
            burst = 1'b0;
        end
        i_out_stall <= burst || hold_cycles != 0;
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off: once, stall the output long enough that the result
    // register fills and the block stalls its input while items keep coming
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && n_checked >= 400) begin
            hold_cycles <= LONG_HOLD;
            hold_done   <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("obd_diagnostic_response_parser_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [7:0]  msg[$];             // message being assembled
    logic [15:0] obd_pool [40];      // recurring codes, to exercise duplicates
    logic [23:0] uds_pool [40];

    task automatic push_item(input logic [1:0] op, input logic [7:0] data,
                             input bit last, input logic [IDX_W-1:0] idx);
        t_op_item it;
        it = '{op: op, data: data, eom: last, idx: idx};
        op_backlog.push_back(it);
        if (op != OP_UNUSED)
            n_stim++;
    endtask

    // Queue the assembled message, mark its last byte, and sprinkle reads
    // between bytes when asked
    task automatic push_msg(input bit mix_reads);
        for (int i = 0; i < msg.size(); i++) begin
            if (mix_reads && i != 0 && $urandom_range(0, 24) == 0)
                push_item(OP_READ, 8'($urandom), 1'($urandom), 5'($urandom));
            push_item(OP_BYTE, msg[i], i == msg.size() - 1, 5'($urandom));
        end
    endtask

    initial begin
        int          pick;
        int          n;
        logic [15:0] obd;
        logic [31:0] raw;
        bit          long_done;

        // Model reset state
        msg_pos = 0;  svc_byte = '0;  sub_byte = '0;  last_bytes = '0;
        pairs_stopped = 1'b0;  n_codes = 0;  odo_miles = '0;  vin_len = 0;
        long_done = 1'b0;

        for (int i = 0; i < 40; i++) begin
            obd_pool[i] = 16'($urandom_range(1, 16'hFFFF));
            uds_pool[i] = 24'($urandom);
        end

        // Directed: empty reads and the unused code first
        push_item(OP_READ, 8'h00, 1'b0, 5'd0);
        push_item(OP_UNUSED, 8'hFF, 1'b1, 5'd31);
        // OBD pairs: lowest and highest codes, then a 00 00 stop and a
        // pair that must be dropped
        msg = '{8'h43, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34};
        push_msg(1'b0);
        // One UDS record
        msg = '{8'h59, 8'h02, 8'hFF, 8'hAB, 8'hCD, 8'hEF, 8'h08};
        push_msg(1'b0);
        // Largest odometer reading
        msg = '{8'h41, 8'hA6, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        push_msg(1'b0);
        // Read the UDS entry, clear, then read an emptied slot
        push_item(OP_READ, 8'h00, 1'b0, 5'd2);
        push_item(OP_CLEAR, 8'hFF, 1'b1, 5'd0);
        push_item(OP_READ, 8'h00, 1'b0, 5'd0);

        // Random: mostly well-formed messages with random content, some
        // wrong sub-functions, truncations and noise
        while (n_stim < STIM_ITEMS) begin
            msg.delete();
            pick = $urandom_range(0, 99);
            if (!long_done && n_stim > 500) begin
                // Overlong OBD message: fills the table, then runs past the
                // byte limit
                long_done = 1'b1;
                msg.push_back(SVC_OBD_DTC);
                for (int i = 0; i < 140; i++) begin
                    obd = obd_pool[$urandom_range(0, 39)];
                    if ($urandom_range(0, 1) == 0)
                        obd = 16'($urandom_range(1, 16'hFFFF));
                    msg.push_back(obd[15:8]);
                    msg.push_back(obd[7:0]);
                end
                push_msg(1'b0);
                continue;
            end
            if (pick < 22) begin
                msg.push_back(SVC_OBD_DTC);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    obd = ($urandom_range(0, 2) != 0) ? obd_pool[$urandom_range(0, 39)]
                                                      : 16'($urandom);
                    if ($urandom_range(0, 9) == 0)
                        obd = 16'h0000;
                    msg.push_back(obd[15:8]);
                    msg.push_back(obd[7:0]);
                end
            end else if (pick < 42) begin
                msg.push_back(SVC_UDS_DTC);
                msg.push_back(($urandom_range(0, 9) != 0) ? UDS_DTC_BY_MASK : 8'($urandom));
                msg.push_back(8'($urandom));
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    raw = ($urandom_range(0, 2) != 0) ? 32'(uds_pool[$urandom_range(0, 39)])
                                                      : 32'($urandom);
                    msg.push_back(raw[23:16]);
                    msg.push_back(raw[15:8]);
                    msg.push_back(raw[7:0]);
                    msg.push_back(8'($urandom));
                end
            end else if (pick < 54) begin
                msg.push_back(SVC_PID);
                msg.push_back(($urandom_range(0, 9) != 0) ? PID_ODOMETER : 8'($urandom));
                case ($urandom_range(0, 5))
                    0:       raw = 32'h0000_0000;
                    1:       raw = 32'hFFFF_FFFF;
                    2:       raw = 32'($urandom_range(0, 99));
                    default: raw = $urandom;
                endcase
                for (int i = 3; i >= 0; i--)
                    msg.push_back(raw[8*i +: 8]);
                if ($urandom_range(0, 6) == 0)
                    msg.push_back(8'($urandom));
            end else if (pick < 70) begin
                msg.push_back(SVC_VEH_INFO);
                msg.push_back(($urandom_range(0, 9) != 0) ? INFO_VIN : 8'($urandom));
                msg.push_back(8'h01);
                n = $urandom_range(15, 24);
                for (int i = 0; i < n; i++)
                    msg.push_back(($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h21, 8'h7E))
                                                              : 8'($urandom));
            end else if (pick < 78) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    msg.push_back(8'($urandom));
            end else if (pick < 92) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_item(OP_READ, 8'($urandom), 1'($urandom),
                              ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 7))
                                                          : 5'($urandom));
            end else if (pick < 94) begin
                push_item(OP_CLEAR, 8'($urandom), 1'($urandom), 5'($urandom));
            end else begin
                push_item(OP_UNUSED, 8'($urandom), 1'($urandom), 5'($urandom));
            end
            // Cut some messages short; the end mark lands on the new last byte
            if (msg.size() > 1 && $urandom_range(0, 9) == 0)
                msg = msg[0 : $urandom_range(0, msg.size() - 2)];
            if (msg.size() != 0)
                push_msg(1'b1);
        end

        // Reset, then let the driver run
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // Catch any stray result after the last expected one
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d results for %0d transfers: %0d reads (%0d on stored codes), %0d clears.",
                 n_checked, n_sent, n_reads, n_hits, n_clears);
        $display("Code table reached %0d entries %0d times; final VIN length %0d, mileage %0d.",
                 MAX_CODES, n_fills, vin_len, odo_miles);
        if (n_errors == 0) begin
            $display("obd_diagnostic_response_parser_unit test passed");
        end else begin
            $display("obd_diagnostic_response_parser_unit test failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/odrp_pkg.sv
design/odrp_ram.sv
design/odrp_div10.sv
design/obd_diagnostic_response_parser_unit.sv
sim/obd_diagnostic_response_parser_unit_test.sv
